// ===== rtl/core/hly_pkg.sv =====
`timescale 1ns / 1ps

package hly_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int LOG_FRAC      = 26;
    localparam int PROD_W        = 66;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_JAC,
        ST_TB,
        ST_TJ,
        ST_XX,
        ST_AXX,
        ST_BX,
        ST_SQ0,
        ST_SQ1,
        ST_SQRT,
        ST_MSB,
        ST_LOG,
        ST_ACC,
        ST_DIVS,
        ST_DIV,
        ST_DIVW,
        ST_DOT0,
        ST_DOT1,
        ST_GS0,
        ST_GS1,
        ST_FIN,
        ST_OUT
    } t_state;

    function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(64'sh7fff_ffff);
        lo = -hi - PROD_W'(1);
        if (v > hi) begin
            return 32'h7fff_ffff;
        end else if (v < lo) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [47:0] sat48(input logic signed [48:0] v);
        if (v[48] != v[47]) begin
            return v[48] ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
        end
        return v[47:0];
    endfunction

endpackage

// ===== rtl/core/hly_isqrt.sv =====
`timescale 1ns / 1ps

module hly_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [34:0] r_rem;
    logic [31:0] r_root;

    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    // two radicand bits brought down per step, one root bit out
    assign rem_sh = {r_rem[32:0], r_rad[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/core/henon_lyapunov_spectrum.sv =====
`timescale 1ns / 1ps

// Henon map Lyapunov spectrum accumulator. Each request on the slave stream
// (tdata bit 0 = restart) advances the map point one step, carries two tangent
// vectors through the Jacobian, orthonormalises them by Gram-Schmidt and adds
// log2 of both lengths to two Q22.26 running sums; one result follows on the
// master stream per request. All arithmetic runs on one registered 33x33
// multiplier, a 2-bit-per-cycle square root and a 1-bit-per-cycle divider
// under a sequencer, and the block is busy meanwhile: the bulk of a step lies
// in the two square roots, the two log2 evaluations (26 squaring rounds plus
// a normalising shift each) and four divisions; a zero-length tangent skips
// its log2 and divisions. A request past the step limit skips the step and
// gives its result from the check state through the output state, with done
// set. A result that is not taken holds the block before it loads the next
// one. The user must write coefficients, start point and step limit through
// the config port only while idle; the block itself does not enforce it.
module henon_lyapunov_spectrum #(
    parameter int FRAC_BITS = hly_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hly_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                    i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [0] restart, rest zero
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] next_x, [63:32] next_y, [111:64] first_log_sum,
    // [159:112] second_log_sum, [191:160] steps_done
    output logic [191:0]                   m_axis_tdata,
    output logic [1:0]                     m_axis_tuser    // [0] degenerate, [1] done_res
);

    localparam int PW = hly_pkg::PROD_W;
    localparam longint A_RST = ((64'sd7 <<< FRAC_BITS) + 64'sd2) / 64'sd5;
    localparam longint B_RST = ((64'sd3 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] ONE  = PW'(1) <<< FRAC_BITS;
    localparam int DW = 32 + FRAC_BITS;

    hly_pkg::t_state r_state, n_state;

    // configuration
    logic [31:0] r_coef_a, r_coef_b, r_start_x, r_start_y;
    logic [30:0] r_limit;

    // step state
    logic [31:0] r_x, r_y, r_f0, r_f1, r_s0, r_s1;
    logic [47:0] r_sum0, r_sum1;
    logic [31:0] r_steps;

    // working registers
    logic [31:0] r_jac, r_tmp, r_tmp2, r_inner, r_len, r_m32, r_q, r_dlo;
    logic [30:0] r_m;
    logic [25:0] r_frac;
    logic [4:0]  r_p;
    logic [5:0]  r_cnt;
    logic [63:0] r_sq;
    logic [32:0] r_rem;
    logic signed [PW-1:0] r_prod, r_dot;
    logic        r_wait, r_vec, r_comp, r_ovf, r_neg, r_deg, r_done;

    // output stage
    logic        r_ovalid;
    logic [191:0] r_odata;
    logic [1:0]  r_ouser;

    logic signed [32:0] op_a, op_b;
    logic signed [PW-1:0] prod_rnd;
    logic [31:0] cur0, cur1, cmp_c, cmp_mag, q_sat;
    logic [DW-1:0] dvd;
    logic [32:0] rem_sh;
    logic        div_ge;
    logic [31:0] sq_hi;
    logic signed [7:0] log_int;
    logic [47:0] log_val;
    logic        sqrt_start, sqrt_done;
    logic [31:0] sqrt_root;
    logic        accept, out_free;

    function automatic logic signed [32:0] sx(input logic [31:0] v);
        return {v[31], v};
    endfunction

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign cur0     = r_vec ? r_s0 : r_f0;
    assign cur1     = r_vec ? r_s1 : r_f1;
    assign prod_rnd = (r_prod + HALF) >>> FRAC_BITS;
    assign sq_hi    = r_prod[61:30];
    assign log_int  = 8'(r_p) - 8'(FRAC_BITS);
    assign log_val  = {{14{log_int[7]}}, log_int, r_frac};

    assign cmp_c   = r_comp ? cur1 : cur0;
    assign cmp_mag = cmp_c[31] ? (32'd0 - cmp_c) : cmp_c;
    assign dvd     = {cmp_mag, {FRAC_BITS{1'b0}}};
    assign rem_sh  = {r_rem[31:0], r_dlo[31]};
    assign div_ge  = rem_sh >= {1'b0, r_len};

    always_comb begin
        if (r_neg) begin
            q_sat = (r_ovf || r_q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - r_q);
        end else begin
            q_sat = (r_ovf || r_q[31]) ? 32'h7fff_ffff : r_q;
        end
    end

    hly_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_sq + r_prod[63:0]),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hly_pkg::ST_IDLE:  if (accept) n_state = hly_pkg::ST_CHECK;
            hly_pkg::ST_CHECK: n_state = (r_steps > {1'b0, r_limit}) ? hly_pkg::ST_OUT
                                                                      : hly_pkg::ST_JAC;
            hly_pkg::ST_JAC:   if (r_wait) n_state = hly_pkg::ST_TB;
            hly_pkg::ST_TB:    if (r_wait) n_state = hly_pkg::ST_TJ;
            hly_pkg::ST_TJ:    if (r_wait) n_state = r_vec ? hly_pkg::ST_XX : hly_pkg::ST_TB;
            hly_pkg::ST_XX:    if (r_wait) n_state = hly_pkg::ST_AXX;
            hly_pkg::ST_AXX:   if (r_wait) n_state = hly_pkg::ST_BX;
            hly_pkg::ST_BX:    if (r_wait) n_state = hly_pkg::ST_SQ0;
            hly_pkg::ST_SQ0:   if (r_wait) n_state = hly_pkg::ST_SQ1;
            hly_pkg::ST_SQ1:   if (r_wait) n_state = hly_pkg::ST_SQRT;
            hly_pkg::ST_SQRT: begin
                if (sqrt_done) begin
                    if (sqrt_root != 32'd0) n_state = hly_pkg::ST_MSB;
                    else n_state = r_vec ? hly_pkg::ST_FIN : hly_pkg::ST_DOT0;
                end
            end
            hly_pkg::ST_MSB:   if (r_m32[31]) n_state = hly_pkg::ST_LOG;
            hly_pkg::ST_LOG: begin
                if (r_wait && r_cnt == 6'(hly_pkg::LOG_FRAC - 1)) n_state = hly_pkg::ST_ACC;
            end
            hly_pkg::ST_ACC:   n_state = hly_pkg::ST_DIVS;
            hly_pkg::ST_DIVS:  n_state = hly_pkg::ST_DIV;
            hly_pkg::ST_DIV:   if (r_cnt == 6'd31) n_state = hly_pkg::ST_DIVW;
            hly_pkg::ST_DIVW: begin
                if (!r_comp) n_state = hly_pkg::ST_DIVS;
                else n_state = r_vec ? hly_pkg::ST_FIN : hly_pkg::ST_DOT0;
            end
            hly_pkg::ST_DOT0:  if (r_wait) n_state = hly_pkg::ST_DOT1;
            hly_pkg::ST_DOT1:  if (r_wait) n_state = hly_pkg::ST_GS0;
            hly_pkg::ST_GS0:   if (r_wait) n_state = hly_pkg::ST_GS1;
            hly_pkg::ST_GS1:   if (r_wait) n_state = hly_pkg::ST_SQ0;
            hly_pkg::ST_FIN:   n_state = hly_pkg::ST_OUT;
            hly_pkg::ST_OUT:   if (out_free) n_state = hly_pkg::ST_IDLE;
            default:           n_state = hly_pkg::ST_IDLE;
        endcase
    end

    // multiplier operands and control outputs
    always_comb begin
        op_a          = '0;
        op_b          = '0;
        s_axis_tready = 1'b0;
        sqrt_start    = 1'b0;
        unique case (r_state)
            hly_pkg::ST_IDLE: s_axis_tready = 1'b1;
            hly_pkg::ST_JAC:  begin op_a = sx(r_coef_a); op_b = sx(r_x); end
            hly_pkg::ST_TB:   begin op_a = sx(r_coef_b); op_b = sx(cur0); end
            hly_pkg::ST_TJ:   begin op_a = sx(r_jac);    op_b = sx(cur0); end
            hly_pkg::ST_XX:   begin op_a = sx(r_x);      op_b = sx(r_x); end
            hly_pkg::ST_AXX:  begin op_a = sx(r_coef_a); op_b = sx(r_tmp); end
            hly_pkg::ST_BX:   begin op_a = sx(r_coef_b); op_b = sx(r_x); end
            hly_pkg::ST_SQ0:  begin op_a = sx(cur0);     op_b = sx(cur0); end
            hly_pkg::ST_SQ1: begin
                op_a       = sx(cur1);
                op_b       = sx(cur1);
                sqrt_start = r_wait;
            end
            hly_pkg::ST_LOG:  begin op_a = {2'b00, r_m}; op_b = {2'b00, r_m}; end
            hly_pkg::ST_DOT0: begin op_a = sx(r_s0);     op_b = sx(r_f0); end
            hly_pkg::ST_DOT1: begin op_a = sx(r_s1);     op_b = sx(r_f1); end
            hly_pkg::ST_GS0:  begin op_a = sx(r_inner);  op_b = sx(r_f0); end
            hly_pkg::ST_GS1:  begin op_a = sx(r_inner);  op_b = sx(r_f1); end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(op_a * op_b);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hly_pkg::ST_IDLE;
            r_wait    <= 1'b0;
            r_ovalid  <= 1'b0;
            r_coef_a  <= 32'(A_RST);
            r_coef_b  <= 32'(B_RST);
            r_start_x <= 32'(B_RST);
            r_start_y <= 32'(B_RST);
            r_limit   <= 31'd1000;
            r_x       <= 32'(B_RST);
            r_y       <= 32'(B_RST);
            r_f0      <= 32'(ONE);
            r_f1      <= '0;
            r_s0      <= '0;
            r_s1      <= 32'(ONE);
            r_sum0    <= '0;
            r_sum1    <= '0;
            r_steps   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) r_wait <= 1'b0;
            else r_wait <= !r_wait;
            if (r_state == hly_pkg::ST_OUT && out_free) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hly_pkg::CFG_COEF_A:     r_coef_a  <= i_cfg_wdata;
                    hly_pkg::CFG_COEF_B:     r_coef_b  <= i_cfg_wdata;
                    hly_pkg::CFG_START_X:    r_start_x <= i_cfg_wdata;
                    hly_pkg::CFG_START_Y:    r_start_y <= i_cfg_wdata;
                    hly_pkg::CFG_STEP_LIMIT: r_limit   <= i_cfg_wdata[30:0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                hly_pkg::ST_IDLE: begin
                    if (accept && s_axis_tdata[0]) begin
                        r_x     <= r_start_x;
                        r_y     <= r_start_y;
                        r_f0    <= 32'(ONE);
                        r_f1    <= '0;
                        r_s0    <= '0;
                        r_s1    <= 32'(ONE);
                        r_sum0  <= '0;
                        r_sum1  <= '0;
                        r_steps <= '0;
                    end
                end
                hly_pkg::ST_TJ: begin
                    if (r_wait) begin
                        if (r_vec) begin
                            r_s0 <= hly_pkg::sat32(prod_rnd + PW'(signed'(cur1)));
                            r_s1 <= r_tmp;
                        end else begin
                            r_f0 <= hly_pkg::sat32(prod_rnd + PW'(signed'(cur1)));
                            r_f1 <= r_tmp;
                        end
                    end
                end
                hly_pkg::ST_BX: begin
                    if (r_wait) begin
                        r_y <= hly_pkg::sat32(prod_rnd);
                        r_x <= r_tmp2;
                    end
                end
                hly_pkg::ST_ACC: begin
                    if (r_vec) r_sum1 <= hly_pkg::sat48({r_sum1[47], r_sum1}
                                                         + {log_val[47], log_val});
                    else r_sum0 <= hly_pkg::sat48({r_sum0[47], r_sum0}
                                                   + {log_val[47], log_val});
                end
                hly_pkg::ST_DIVW: begin
                    unique case ({r_vec, r_comp})
                        2'b00: r_f0 <= q_sat;
                        2'b01: r_f1 <= q_sat;
                        2'b10: r_s0 <= q_sat;
                        default: r_s1 <= q_sat;
                    endcase
                end
                hly_pkg::ST_GS0: begin
                    if (r_wait) r_s0 <= hly_pkg::sat32(PW'(signed'(r_s0)) - prod_rnd);
                end
                hly_pkg::ST_GS1: begin
                    if (r_wait) r_s1 <= hly_pkg::sat32(PW'(signed'(r_s1)) - prod_rnd);
                end
                hly_pkg::ST_FIN: r_steps <= r_steps + 32'd1;
                default: begin
                end
            endcase
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            hly_pkg::ST_IDLE: begin
                r_vec  <= 1'b0;
                r_deg  <= 1'b0;
                r_done <= 1'b0;
            end
            hly_pkg::ST_CHECK: r_done <= r_steps > {1'b0, r_limit};
            hly_pkg::ST_JAC: if (r_wait) r_jac <= hly_pkg::sat32(-(prod_rnd <<< 1));
            hly_pkg::ST_TB:  if (r_wait) r_tmp <= hly_pkg::sat32(prod_rnd);
            hly_pkg::ST_TJ:  if (r_wait) r_vec <= !r_vec;
            hly_pkg::ST_XX:  if (r_wait) r_tmp <= hly_pkg::sat32(prod_rnd);
            hly_pkg::ST_AXX: begin
                if (r_wait) begin
                    r_tmp2 <= hly_pkg::sat32(ONE - PW'(signed'(hly_pkg::sat32(prod_rnd)))
                                             + PW'(signed'(r_y)));
                end
            end
            hly_pkg::ST_SQ0: if (r_wait) r_sq <= r_prod[63:0];
            hly_pkg::ST_SQRT: begin
                if (sqrt_done) begin
                    r_len <= sqrt_root;
                    r_m32 <= sqrt_root;
                    r_p   <= 5'd31;
                    if (sqrt_root == 32'd0) r_deg <= 1'b1;
                end
            end
            hly_pkg::ST_MSB: begin
                if (r_m32[31]) begin
                    r_m    <= r_m32[31:1];
                    r_cnt  <= '0;
                    r_frac <= '0;
                end else begin
                    r_m32 <= {r_m32[30:0], 1'b0};
                    r_p   <= r_p - 5'd1;
                end
            end
            hly_pkg::ST_LOG: begin
                if (r_wait) begin
                    // a square of two or more gives a one bit and halves
                    r_frac <= {r_frac[24:0], sq_hi[31]};
                    r_m    <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
                    r_cnt  <= r_cnt + 6'd1;
                end
            end
            hly_pkg::ST_ACC: r_comp <= 1'b0;
            hly_pkg::ST_DIVS: begin
                r_neg <= cmp_c[31];
                r_ovf <= {{(32 - FRAC_BITS){1'b0}}, dvd[DW-1:32]} >= r_len;
                r_rem <= {{(33 - FRAC_BITS){1'b0}}, dvd[DW-1:32]};
                r_dlo <= dvd[31:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            hly_pkg::ST_DIV: begin
                r_rem <= div_ge ? (rem_sh - {1'b0, r_len}) : rem_sh;
                r_q   <= {r_q[30:0], div_ge};
                r_dlo <= {r_dlo[30:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
            end
            hly_pkg::ST_DIVW: r_comp <= 1'b1;
            hly_pkg::ST_DOT0: if (r_wait) r_dot <= r_prod;
            hly_pkg::ST_DOT1: begin
                if (r_wait) r_inner <= hly_pkg::sat32((r_dot + r_prod + HALF) >>> FRAC_BITS);
            end
            hly_pkg::ST_GS1: if (r_wait) r_vec <= 1'b1;
            default: begin
            end
        endcase
    end

    // result register, loaded only once the previous result has gone
    always_ff @(posedge i_clk) begin
        if (r_state == hly_pkg::ST_OUT && out_free) begin
            r_odata <= {r_steps, r_sum1, r_sum0, r_y, r_x};
            r_ouser <= {r_done, r_deg && !r_done};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule
